// ===== design/mqfe_pkg.sv =====
// Shared types and constants of the multi-queue FIFO engine.
// Used by the channel interfaces, the controller, the datapath and the top level.
package mqfe_pkg;

  // Default sizes of the queue pool.
  localparam int unsigned DEF_NUM_QUEUES     = 8;
  localparam int unsigned DEF_SLOTS_PER_QUEUE = 16;
  localparam int unsigned DEF_MAX_ELEM_BYTES = 8;

  // Field widths of the channels.
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned QID_IN_W = 4;
  localparam int unsigned EB_W     = 4;
  localparam int unsigned EC_W     = 5;
  localparam int unsigned XB_W     = 4;
  localparam int unsigned DATA_W   = 64;
  localparam int unsigned STAT_W   = 4;
  localparam int unsigned NEWID_W  = 3;
  localparam int unsigned BYTES_W  = DATA_W / 8;

  // Operation codes.
  typedef enum logic [MODE_W-1:0] {
    MODE_CREATE  = 2'd0,
    MODE_WRITE   = 2'd1,
    MODE_READ    = 2'd2,
    MODE_DESTROY = 2'd3
  } mode_e;

  // Status codes returned with every operation.
  typedef enum logic [STAT_W-1:0] {
    STAT_OK          = 4'd0,
    STAT_BAD_PARAM   = 4'd1,
    STAT_NO_FREE     = 4'd2,
    STAT_BAD_HANDLE  = 4'd3,
    STAT_NOT_CREATED = 4'd4,
    STAT_TOO_BIG     = 4'd5,
    STAT_FULL        = 4'd6,
    STAT_EMPTY       = 4'd7,
    STAT_NOT_EMPTY   = 4'd8
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;   // transaction accepted: decode, latch, read slot
    logic commit;  // apply the operation and load the result register
  } dp_cmd_t;

endpackage

// ===== design/mqfe_if.sv =====
// Valid/ready channel interfaces of the multi-queue FIFO engine.
// Depends on mqfe_pkg for field widths.
interface mqfe_in_if;
  import mqfe_pkg::*;

  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [QID_IN_W-1:0] queue_id;
  logic [EB_W-1:0]     elem_bytes;
  logic [EC_W-1:0]     elem_count;
  logic [XB_W-1:0]     xfer_bytes;
  logic [DATA_W-1:0]   write_data;

  modport source (
    output valid, mode, queue_id, elem_bytes, elem_count, xfer_bytes, write_data,
    input  ready
  );
  modport sink (
    input  valid, mode, queue_id, elem_bytes, elem_count, xfer_bytes, write_data,
    output ready
  );
endinterface

interface mqfe_out_if;
  import mqfe_pkg::*;

  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [DATA_W-1:0]  read_data;
  logic [NEWID_W-1:0] new_queue_id;

  modport source (
    output valid, status, read_data, new_queue_id,
    input  ready
  );
  modport sink (
    input  valid, status, read_data, new_queue_id,
    output ready
  );
endinterface

// ===== design/multi_queue_fifo_engine_top.sv =====
// Top level of the multi-queue FIFO engine: pool of circular FIFOs over one slot RAM.
// Depends on mqfe_pkg, mqfe_if, mqfe_ctrl, mqfe_dp and mqfe_ram.
//
//   channel  dir  handshake      payload
//   in_i     in   valid/ready    mode, queue_id, elem_bytes, elem_count, xfer_bytes, write_data
//   out_o    out  valid/ready    status, read_data, new_queue_id
//
// A transaction is split: the accept cycle decodes it and reads the slot RAM, and the
// commit, once the result register is free, merges or masks the slot word, writes it
// back and loads the result register. The single slot RAM port forces this split.
// Reset clears the queue table at once; slot contents are not cleared.
// A result held by a stalled output blocks the next commit; one new transaction
// can still be accepted behind it.
module multi_queue_fifo_engine_top #(
  parameter int unsigned NUM_QUEUES      = mqfe_pkg::DEF_NUM_QUEUES,
  parameter int unsigned SLOTS_PER_QUEUE = mqfe_pkg::DEF_SLOTS_PER_QUEUE,
  parameter int unsigned MAX_ELEM_BYTES  = mqfe_pkg::DEF_MAX_ELEM_BYTES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  mqfe_in_if.sink           in_i,
  mqfe_out_if.source        out_o
);
  import mqfe_pkg::*;

  dp_cmd_t cmd;

  mqfe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  mqfe_dp #(
    .NUM_QUEUES      (NUM_QUEUES),
    .SLOTS_PER_QUEUE (SLOTS_PER_QUEUE),
    .MAX_ELEM_BYTES  (MAX_ELEM_BYTES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .mode_i         (in_i.mode),
    .queue_id_i     (in_i.queue_id),
    .elem_bytes_i   (in_i.elem_bytes),
    .elem_count_i   (in_i.elem_count),
    .xfer_bytes_i   (in_i.xfer_bytes),
    .write_data_i   (in_i.write_data),
    .status_o       (out_o.status),
    .read_data_o    (out_o.read_data),
    .new_queue_id_o (out_o.new_queue_id)
  );

endmodule

// ===== design/mqfe_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies; holds the shared slot store of the engine.
module mqfe_ram #(
  parameter  int unsigned WIDTH  = 64,
  parameter  int unsigned DEPTH  = 128,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write on we, register the read word on re.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/mqfe_ctrl.sv =====
// Controller of the multi-queue FIFO engine: handshake and operation sequencing.
// Depends on mqfe_pkg for the datapath command struct.
module mqfe_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mqfe_pkg::dp_cmd_t cmd_o
);
  import mqfe_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   start, commit;

  // Accept in idle; commit once the result register is free.
  assign in_ready_o = (state_q == ST_IDLE);
  assign start      = in_valid_i && in_ready_o;
  assign commit     = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Result valid: set on commit, drop when taken.
  assign out_valid_d = commit || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cmd_o.start  = start;
  assign cmd_o.commit = commit;

`ifndef NO_ASSERTIONS
  a_commit_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_q)
    else $error("result not presented after commit");

  a_start_enters_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> (state_q == ST_EXEC))
    else $error("accepted transaction did not enter execution");

  a_stall_holds_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && out_valid_q && !out_ready_i) |=> (state_q == ST_EXEC))
    else $error("operation finished while result register was blocked");
`endif

endmodule

// ===== design/mqfe_dp.sv =====
// Datapath of the multi-queue FIFO engine: queue table, decode, slot RAM, result register.
// Depends on mqfe_pkg and mqfe_ram.
module mqfe_dp #(
  parameter int unsigned NUM_QUEUES      = mqfe_pkg::DEF_NUM_QUEUES,
  parameter int unsigned SLOTS_PER_QUEUE = mqfe_pkg::DEF_SLOTS_PER_QUEUE,
  parameter int unsigned MAX_ELEM_BYTES  = mqfe_pkg::DEF_MAX_ELEM_BYTES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mqfe_pkg::dp_cmd_t             cmd_i,
  input  logic [mqfe_pkg::MODE_W-1:0]   mode_i,
  input  logic [mqfe_pkg::QID_IN_W-1:0] queue_id_i,
  input  logic [mqfe_pkg::EB_W-1:0]     elem_bytes_i,
  input  logic [mqfe_pkg::EC_W-1:0]     elem_count_i,
  input  logic [mqfe_pkg::XB_W-1:0]     xfer_bytes_i,
  input  logic [mqfe_pkg::DATA_W-1:0]   write_data_i,
  output logic [mqfe_pkg::STAT_W-1:0]   status_o,
  output logic [mqfe_pkg::DATA_W-1:0]   read_data_o,
  output logic [mqfe_pkg::NEWID_W-1:0]  new_queue_id_o
);
  import mqfe_pkg::*;

  localparam int unsigned QID_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned IDX_W  = (SLOTS_PER_QUEUE > 1) ? $clog2(SLOTS_PER_QUEUE) : 1;
  localparam int unsigned CNT_W  = $clog2(SLOTS_PER_QUEUE + 1);
  localparam int unsigned DEPTH  = NUM_QUEUES * SLOTS_PER_QUEUE;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Queue table.
  logic [NUM_QUEUES-1:0] in_use_q;
  logic [EB_W-1:0]       eb_q    [NUM_QUEUES];
  logic [CNT_W-1:0]      cap_q   [NUM_QUEUES];
  logic [IDX_W-1:0]      ridx_q  [NUM_QUEUES];
  logic [IDX_W-1:0]      widx_q  [NUM_QUEUES];
  logic [CNT_W-1:0]      fill_q  [NUM_QUEUES];

  // Decode signals.
  mode_e              mode_d;
  status_e            status_d;
  logic               handle_ok, param_ok, free_found;
  logic [QID_W-1:0]   qsel, free_idx, sel_d;
  logic               q_in_use;
  logic [EB_W-1:0]    q_eb;
  logic [CNT_W-1:0]   q_cap, q_fill;
  logic [IDX_W-1:0]   q_ridx, q_widx, slot_idx;
  logic [ADDR_W-1:0]  rd_addr;

  // Latched operation.
  mode_e              op_q;
  status_e            status_q;
  logic [QID_W-1:0]   sel_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [XB_W-1:0]    xb_q;
  logic [DATA_W-1:0]  wdata_q;
  logic [EB_W-1:0]    eb_new_q;
  logic [CNT_W-1:0]   cap_new_q;

  // Commit signals.
  logic               op_ok;
  logic [DATA_W-1:0]  byte_mask, ram_rdata, merged, popped;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_addr;
  logic [NEWID_W:0]   sel_ext;

  // Result register.
  logic [STAT_W-1:0]  status_out_q;
  logic [DATA_W-1:0]  read_data_q;
  logic [NEWID_W-1:0] new_id_q;

  function automatic logic [IDX_W-1:0] adv_idx(input logic [IDX_W-1:0] idx,
                                               input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] nxt;
    nxt = CNT_W'(idx) + CNT_W'(1);
    return (nxt >= cap) ? '0 : IDX_W'(nxt);
  endfunction

  // Find the lowest free queue.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        free_found = 1'b1;
        free_idx   = QID_W'(i);
      end
    end
  end

  // Look up the addressed queue; an invalid handle reads as empty.
  assign mode_d    = mode_e'(mode_i);
  assign qsel      = queue_id_i[QID_W-1:0];
  assign handle_ok = (32'(queue_id_i) < NUM_QUEUES);
  assign param_ok  = (elem_bytes_i != '0) && (32'(elem_bytes_i) <= MAX_ELEM_BYTES)
                  && (elem_count_i != '0) && (32'(elem_count_i) <= SLOTS_PER_QUEUE);

  always_comb begin
    q_in_use = 1'b0;
    q_eb     = '0;
    q_cap    = '0;
    q_fill   = '0;
    q_ridx   = '0;
    q_widx   = '0;
    if (handle_ok) begin
      q_in_use = in_use_q[qsel];
      q_eb     = eb_q[qsel];
      q_cap    = cap_q[qsel];
      q_fill   = fill_q[qsel];
      q_ridx   = ridx_q[qsel];
      q_widx   = widx_q[qsel];
    end
  end

  // Decide the status in check order.
  always_comb begin
    status_d = STAT_OK;
    if (mode_d == MODE_CREATE) begin
      if (!param_ok) begin
        status_d = STAT_BAD_PARAM;
      end else if (!free_found) begin
        status_d = STAT_NO_FREE;
      end
    end else if (!handle_ok) begin
      status_d = STAT_BAD_HANDLE;
    end else if (!q_in_use) begin
      status_d = STAT_NOT_CREATED;
    end else if (mode_d == MODE_DESTROY) begin
      if (q_fill != '0) begin
        status_d = STAT_NOT_EMPTY;
      end
    end else if (xfer_bytes_i > q_eb) begin
      status_d = STAT_TOO_BIG;
    end else if (mode_d == MODE_WRITE) begin
      if (q_fill >= q_cap) begin
        status_d = STAT_FULL;
      end
    end else if (q_fill == '0) begin
      status_d = STAT_EMPTY;
    end
  end

  assign sel_d    = (mode_d == MODE_CREATE) ? free_idx : qsel;
  assign slot_idx = (mode_d == MODE_WRITE) ? q_widx : q_ridx;
  assign rd_addr  = ADDR_W'(qsel) * ADDR_W'(SLOTS_PER_QUEUE) + ADDR_W'(slot_idx);

  // Latch the decoded operation on accept.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q      <= mode_d;
      status_q  <= status_d;
      sel_q     <= sel_d;
      addr_q    <= rd_addr;
      xb_q      <= xfer_bytes_i;
      wdata_q   <= write_data_i;
      eb_new_q  <= elem_bytes_i;
      cap_new_q <= CNT_W'(elem_count_i);
    end
  end

  // Build the byte mask of the transfer.
  always_comb begin
    for (int b = 0; b < BYTES_W; b++) begin
      byte_mask[8*b +: 8] = (XB_W'(b) < xb_q) ? 8'hFF : 8'h00;
    end
  end

  assign op_ok    = (status_q == STAT_OK);
  assign merged   = (ram_rdata & ~byte_mask) | (wdata_q & byte_mask);
  assign popped   = ram_rdata & byte_mask;
  assign ram_we   = cmd_i.commit && op_ok && (op_q == MODE_WRITE);
  assign ram_addr = cmd_i.commit ? addr_q : rd_addr;

  mqfe_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (cmd_i.start),
    .addr_i  (ram_addr),
    .wdata_i (merged),
    .rdata_o (ram_rdata)
  );

  // Update the queue table on a successful commit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        eb_q[i]   <= '0;
        cap_q[i]  <= '0;
        ridx_q[i] <= '0;
        widx_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else if (cmd_i.commit && op_ok) begin
      case (op_q)
        MODE_CREATE: begin
          in_use_q[sel_q] <= 1'b1;
          eb_q[sel_q]     <= eb_new_q;
          cap_q[sel_q]    <= cap_new_q;
          ridx_q[sel_q]   <= '0;
          widx_q[sel_q]   <= '0;
          fill_q[sel_q]   <= '0;
        end
        MODE_WRITE: begin
          widx_q[sel_q] <= adv_idx(widx_q[sel_q], cap_q[sel_q]);
          fill_q[sel_q] <= fill_q[sel_q] + CNT_W'(1);
        end
        MODE_READ: begin
          ridx_q[sel_q] <= adv_idx(ridx_q[sel_q], cap_q[sel_q]);
          fill_q[sel_q] <= fill_q[sel_q] - CNT_W'(1);
        end
        MODE_DESTROY: begin
          in_use_q[sel_q] <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Load the result register.
  assign sel_ext = (NEWID_W + 1)'(sel_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_out_q <= status_q;
      read_data_q  <= (op_ok && op_q == MODE_READ) ? popped : '0;
      new_id_q     <= (op_ok && op_q == MODE_CREATE) ? sel_ext[NEWID_W-1:0] : '0;
    end
  end

  assign status_o       = status_out_q;
  assign read_data_o    = read_data_q;
  assign new_queue_id_o = new_id_q;

`ifndef NO_ASSERTIONS
  a_create_claims: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && op_ok && op_q == MODE_CREATE) |=> in_use_q[sel_q])
    else $error("created queue not marked in use");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && op_ok) |-> (fill_q[sel_q] <= cap_q[sel_q]))
    else $error("queue fill count above capacity");

  a_rdata_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && !(op_ok && op_q == MODE_READ)) |=> (read_data_q == '0))
    else $error("read data driven for an operation that popped nothing");
`endif

endmodule

// ===== tb/multi_queue_fifo_engine_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for multi_queue_fifo_engine_top: directed and random queue operations.
// Depends on mqfe_pkg, the mqfe_in_if/mqfe_out_if channel interfaces and the engine RTL.
module multi_queue_fifo_engine_top_test;
  import mqfe_pkg::*;

  localparam int unsigned NQ          = DEF_NUM_QUEUES;
  localparam int unsigned SLOTS       = DEF_SLOTS_PER_QUEUE;
  localparam int unsigned MAX_EB      = DEF_MAX_ELEM_BYTES;
  localparam int unsigned PHASE_OPS   = 210;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_WAIT  = 20;

  // One queue operation and the reply it must produce.
  typedef struct packed {
    mode_e                mode;
    logic [QID_IN_W-1:0]  qid;
    logic [EB_W-1:0]      eb;
    logic [EC_W-1:0]      ec;
    logic [XB_W-1:0]      xb;
    logic [DATA_W-1:0]    wd;
  } queue_op_t;

  typedef struct packed {
    status_e              status;
    logic [DATA_W-1:0]    rdata;
    logic [NEWID_W-1:0]   newid;
  } op_reply_t;

  typedef struct {
    queue_op_t   op;
    op_reply_t   reply;
    int unsigned tx_idle;
    int unsigned rx_stall;
    bit          drain_first;
    bit          rx_hold;
  } planned_op_t;

  logic clk;
  logic rst_n;

  mqfe_in_if  in_bus ();
  mqfe_out_if out_bus ();

  multi_queue_fifo_engine_top uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // Queue table of the predictor
  bit                  q_used [NQ];
  logic [EB_W-1:0]     q_eb   [NQ];
  logic [EC_W-1:0]     q_cap  [NQ];
  logic [3:0]          q_rd   [NQ];
  logic [3:0]          q_wr   [NQ];
  logic [EC_W-1:0]     q_fill [NQ];
  bit [DATA_W-1:0]     slot_mem     [NQ*SLOTS];
  bit [BYTES_W-1:0]    slot_written [NQ*SLOTS];

  planned_op_t pending_ops[$];
  op_reply_t   awaited_replies[$];
  planned_op_t cur_op;

  int unsigned phase_tx_idle;
  int unsigned phase_rx_stall;
  bit          mark_drain;
  bit          mark_hold;

  int unsigned rx_stall_pct;
  logic        rx_hold_req;
  int unsigned rx_hold_cnt;
  int unsigned ops_accepted;
  int unsigned replies_checked;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  bit [15:0]   status_seen;

  function automatic logic [DATA_W-1:0] lane_mask(input int unsigned n);
    if (n >= BYTES_W) return '1;
    return (64'd1 << (8 * n)) - 64'd1;
  endfunction

  function automatic logic [3:0] bump_index(input logic [3:0] idx, input logic [EC_W-1:0] cap);
    if (idx + 1 >= cap) return '0;
    return idx + 1'b1;
  endfunction

  // Apply one operation to the queue table and return its reply
  function automatic op_reply_t apply_queue_op(input queue_op_t op);
    op_reply_t   r;
    int unsigned q;
    int unsigned a;
    logic [DATA_W-1:0] m;
    r.status = STAT_OK;
    r.rdata  = '0;
    r.newid  = '0;
    if (op.mode == MODE_CREATE) begin
      if (op.eb == 0 || op.eb > MAX_EB || op.ec == 0 || op.ec > SLOTS) begin
        r.status = STAT_BAD_PARAM;
      end else begin
        q = 0;
        while (q < NQ && q_used[q]) q++;
        if (q >= NQ) begin
          r.status = STAT_NO_FREE;
        end else begin
          q_used[q] = 1'b1;
          q_eb[q]   = op.eb;
          q_cap[q]  = op.ec;
          q_rd[q]   = '0;
          q_wr[q]   = '0;
          q_fill[q] = '0;
          r.newid   = q[NEWID_W-1:0];
        end
      end
    end else if (op.qid >= NQ) begin
      r.status = STAT_BAD_HANDLE;
    end else if (!q_used[op.qid]) begin
      r.status = STAT_NOT_CREATED;
    end else if (op.mode == MODE_DESTROY) begin
      if (q_fill[op.qid] != 0) r.status = STAT_NOT_EMPTY;
      else q_used[op.qid] = 1'b0;
    end else if (op.xb > q_eb[op.qid]) begin
      r.status = STAT_TOO_BIG;
    end else if (op.mode == MODE_WRITE) begin
      if (q_fill[op.qid] >= q_cap[op.qid]) begin
        r.status = STAT_FULL;
      end else begin
        a = op.qid * SLOTS + (q_wr[op.qid] % SLOTS);
        m = lane_mask(op.xb);
        slot_mem[a] = (slot_mem[a] & ~m) | (op.wd & m);
        for (int i = 0; i < BYTES_W; i++)
          if (i < op.xb) slot_written[a][i] = 1'b1;
        q_wr[op.qid]   = bump_index(q_wr[op.qid], q_cap[op.qid]);
        q_fill[op.qid] = q_fill[op.qid] + 1'b1;
      end
    end else begin
      if (q_fill[op.qid] == 0) begin
        r.status = STAT_EMPTY;
      end else begin
        a = op.qid * SLOTS + (q_rd[op.qid] % SLOTS);
        r.rdata = slot_mem[a] & lane_mask(op.xb);
        q_rd[op.qid]   = bump_index(q_rd[op.qid], q_cap[op.qid]);
        q_fill[op.qid] = q_fill[op.qid] - 1'b1;
      end
    end
    return r;
  endfunction

  // Shrink a read that would pop a slot so it only covers bytes already written
  function automatic queue_op_t fit_read_size(input queue_op_t op);
    queue_op_t   o;
    int unsigned a;
    int unsigned n;
    o = op;
    if (op.mode == MODE_READ && op.qid < NQ && q_used[op.qid] &&
        op.xb <= q_eb[op.qid] && q_fill[op.qid] != 0) begin
      a = op.qid * SLOTS + (q_rd[op.qid] % SLOTS);
      n = 0;
      while (n < op.xb && slot_written[a][n]) n++;
      o.xb = n[XB_W-1:0];
    end
    return o;
  endfunction

  // Predict one operation and append it to the stimulus backlog
  task automatic plan_op(input mode_e m, input int unsigned qid, input int unsigned eb,
                         input int unsigned ec, input int unsigned xb,
                         input logic [DATA_W-1:0] wd);
    planned_op_t p;
    p.op.mode    = m;
    p.op.qid     = qid[QID_IN_W-1:0];
    p.op.eb      = eb[EB_W-1:0];
    p.op.ec      = ec[EC_W-1:0];
    p.op.xb      = xb[XB_W-1:0];
    p.op.wd      = wd;
    p.op         = fit_read_size(p.op);
    p.reply      = apply_queue_op(p.op);
    p.tx_idle    = phase_tx_idle;
    p.rx_stall   = phase_rx_stall;
    p.drain_first = mark_drain;
    p.rx_hold    = mark_hold;
    mark_drain   = 1'b0;
    mark_hold    = 1'b0;
    pending_ops.push_back(p);
  endtask

  function automatic int pick_live_queue();
    int unsigned live[$];
    for (int q = 0; q < NQ; q++)
      if (q_used[q]) live.push_back(q);
    if (live.size() == 0) return -1;
    return live[$urandom_range(0, live.size() - 1)];
  endfunction

  // Mostly legal operations on live queues, with some fully random noise
  task automatic plan_random_op();
    int          q;
    int unsigned r;
    int unsigned xb;
    logic [DATA_W-1:0] wd;
    q  = pick_live_queue();
    r  = $urandom_range(0, 99);
    wd = {$urandom, $urandom};
    if (r < 12) begin
      plan_op(mode_e'($urandom_range(0, 3)), $urandom_range(0, 15), $urandom_range(0, 15),
              $urandom_range(0, 31), $urandom_range(0, 15), wd);
    end else if (r < 27 || q < 0) begin
      plan_op(MODE_CREATE, $urandom_range(0, 15), $urandom_range(1, MAX_EB),
              $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(1, SLOTS),
              $urandom_range(0, 15), wd);
    end else if (r < 87) begin
      if ($urandom_range(0, 9) == 0) xb = $urandom_range(q_eb[q] + 1, 15);
      else xb = $urandom_range(0, q_eb[q]);
      plan_op((r < 57) ? MODE_WRITE : MODE_READ, q, $urandom_range(0, 15),
              $urandom_range(0, 31), xb, wd);
    end else begin
      plan_op(MODE_DESTROY, q, $urandom_range(0, 15), $urandom_range(0, 31),
              $urandom_range(0, 15), wd);
    end
  endtask

  task automatic report_mismatch(input string field, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    mismatches++;
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Sender: offer backlog transactions, idle at random, hold for drain marks
  always @(posedge clk or negedge rst_n) begin : drive_proc
    bit holding;
    bit hold_req;
    if (!rst_n) begin
      in_bus.valid      <= 1'b0;
      in_bus.mode       <= '0;
      in_bus.queue_id   <= '0;
      in_bus.elem_bytes <= '0;
      in_bus.elem_count <= '0;
      in_bus.xfer_bytes <= '0;
      in_bus.write_data <= '0;
      rx_hold_req       <= 1'b0;
      rx_stall_pct      <= 0;
      ops_accepted      <= 0;
    end else begin
      holding  = in_bus.valid && !in_bus.ready;
      hold_req = 1'b0;
      if (in_bus.valid && in_bus.ready) begin
        awaited_replies.push_back(cur_op.reply);
        rx_stall_pct <= cur_op.rx_stall;
        hold_req      = cur_op.rx_hold;
        ops_accepted <= ops_accepted + 1;
      end
      if (!holding) begin
        if (pending_ops.size() != 0 &&
            !(pending_ops[0].drain_first && awaited_replies.size() != 0) &&
            $urandom_range(0, 99) >= pending_ops[0].tx_idle) begin
          cur_op = pending_ops.pop_front();
          in_bus.valid      <= 1'b1;
          in_bus.mode       <= cur_op.op.mode;
          in_bus.queue_id   <= cur_op.op.qid;
          in_bus.elem_bytes <= cur_op.op.eb;
          in_bus.elem_count <= cur_op.op.ec;
          in_bus.xfer_bytes <= cur_op.op.xb;
          in_bus.write_data <= cur_op.op.wd;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
      rx_hold_req <= hold_req;
    end
  end

  // Long receiver hold-off, counted down on its own
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      rx_hold_cnt <= 0;
    end else if (rx_hold_req) begin
      rx_hold_cnt <= HOLD_CYCLES;
    end else if (rx_hold_cnt != 0) begin
      rx_hold_cnt <= rx_hold_cnt - 1;
    end
  end

  // Receiver: check each reply against the oldest prediction, stall at random
  always @(posedge clk or negedge rst_n) begin : check_proc
    op_reply_t want;
    if (!rst_n) begin
      out_bus.ready   <= 1'b0;
      replies_checked <= 0;
      mismatches      = 0;
      status_seen     <= '0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        replies_checked <= replies_checked + 1;
        status_seen[out_bus.status] <= 1'b1;
        if (awaited_replies.size() == 0) begin
          $display("%0t: unexpected reply, expected none, actual status %0d data %h id %0d",
                   $time, out_bus.status, out_bus.read_data, out_bus.new_queue_id);
          mismatches++;
        end else begin
          want = awaited_replies.pop_front();
          if (out_bus.status !== want.status)
            report_mismatch("status", want.status, out_bus.status);
          if (out_bus.read_data !== want.rdata)
            report_mismatch("read_data", want.rdata, out_bus.read_data);
          if (out_bus.new_queue_id !== want.newid)
            report_mismatch("new_queue_id", want.newid, out_bus.new_queue_id);
        end
      end
      out_bus.ready <= (rx_hold_cnt == 0) && ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Watchdog: abort when no transaction moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("multi_queue_fifo_engine_top verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end else begin
      quiet_cycles <= 0;
    end
  end

  // Stimulus plan, reset and end of run
  initial begin
    rst_n = 1'b0;
    for (int q = 0; q < NQ; q++) begin
      q_used[q] = 1'b0;
      q_eb[q]   = '0;
      q_cap[q]  = '0;
      q_rd[q]   = '0;
      q_wr[q]   = '0;
      q_fill[q] = '0;
    end
    for (int a = 0; a < NQ * SLOTS; a++) slot_written[a] = '0;
    phase_tx_idle  = 0;
    phase_rx_stall = 0;
    mark_drain     = 1'b0;
    mark_hold      = 1'b0;

    // Directed: bad parameters, bad and unknown handles
    plan_op(MODE_CREATE, 0, 0, 4, 0, '0);
    plan_op(MODE_CREATE, 15, 15, 31, 15, '1);
    plan_op(MODE_CREATE, 0, 9, 16, 0, '0);
    plan_op(MODE_CREATE, 0, 8, 17, 0, '0);
    plan_op(MODE_CREATE, 0, 8, 0, 0, '0);
    plan_op(MODE_WRITE, 15, 0, 0, 1, '1);
    plan_op(MODE_DESTROY, 8, 0, 0, 0, '0);
    plan_op(MODE_READ, 3, 0, 0, 1, '0);
    plan_op(MODE_DESTROY, 5, 0, 0, 0, '0);
    // Directed: widest and narrowest queues, full, empty, partial writes
    plan_op(MODE_CREATE, 0, 8, 16, 0, '0);
    plan_op(MODE_CREATE, 0, 2, 1, 0, '0);
    plan_op(MODE_WRITE, 0, 0, 0, 8, '1);
    plan_op(MODE_WRITE, 0, 0, 0, 0, {$urandom, $urandom});
    plan_op(MODE_WRITE, 1, 0, 0, 3, {$urandom, $urandom});
    plan_op(MODE_WRITE, 1, 0, 0, 2, {$urandom, $urandom});
    plan_op(MODE_WRITE, 1, 0, 0, 2, {$urandom, $urandom});
    plan_op(MODE_DESTROY, 1, 0, 0, 0, '0);
    plan_op(MODE_READ, 1, 0, 0, 2, '0);
    plan_op(MODE_READ, 1, 0, 0, 2, '0);
    plan_op(MODE_WRITE, 1, 0, 0, 1, {$urandom, $urandom});
    plan_op(MODE_READ, 1, 0, 0, 2, '0);
    plan_op(MODE_DESTROY, 1, 0, 0, 0, '0);
    plan_op(MODE_READ, 0, 0, 0, 8, '0);
    plan_op(MODE_READ, 0, 0, 0, 0, '0);
    plan_op(MODE_READ, 0, 0, 0, 15, '0);

    // Random phases: no idling, sender idle, receiver stalling, both
    for (int ph = 0; ph < 4; ph++) begin
      phase_tx_idle  = (ph == 1) ? 82 : (ph == 3) ? 11 : 0;
      phase_rx_stall = (ph == 2) ? 82 : (ph == 3) ? 11 : 0;
      mark_drain     = 1'b1;
      for (int k = 0; k < PHASE_OPS; k++) begin
        if (ph == 0 && k == 20) mark_hold = 1'b1;
        plan_random_op();
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Wait for the backlog to drain and every reply to arrive
    while (pending_ops.size() != 0 || in_bus.valid || awaited_replies.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Ran %0d queue operations over four idling phases, %0d replies compared,",
             ops_accepted, replies_checked);
    $display("%0d of 9 status codes returned, %0d mismatches", $countones(status_seen),
             mismatches);
    if (mismatches == 0 && awaited_replies.size() == 0) begin
      $display("multi_queue_fifo_engine_top verification clean");
    end else begin
      $display("multi_queue_fifo_engine_top verification failed");
    end
    $finish;
  end

endmodule
